### hdl/cfr_pkg.sv
// Shared types and constants for the checked frame receiver.
`timescale 1ns / 1ps

package cfr_pkg;

    localparam int CFR_MAX_PAYLOAD = 256;
    localparam int OVERHEAD        = 8;   // head, src, dst, func, 2 length, sum, add
    localparam int HEAD_BYTES      = 6;
    localparam int LEN_W           = 16;
    localparam int CMP_W           = LEN_W + 1;

    localparam logic [7:0] HEAD_RESET = 8'hAA;

    typedef enum logic [3:0] {
        ROLE_HUNT     = 4'd0,
        ROLE_HEAD     = 4'd1,
        ROLE_SOURCE   = 4'd2,
        ROLE_DEST     = 4'd3,
        ROLE_FUNCTION = 4'd4,
        ROLE_LENGTH   = 4'd5,
        ROLE_PAYLOAD  = 4'd6,
        ROLE_SUM      = 4'd7,
        ROLE_ADD      = 4'd8
    } t_role;

    typedef struct packed {
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       function_code;
        logic             frame_dropped;
        logic             frame_good;
        logic             frame_end;
        logic [7:0]       payload_index;
        t_role            byte_role;
        logic [7:0]       byte_value;
    } t_result;

endpackage

### hdl/checked_frame_receiver.sv
// Top level: frame parser with a two-entry registered result stage.
// The result of each accepted item is registered before it appears on the master side.
// Throughput: one item per cycle while the skid register is empty; the frame state update is combinational.
// A skid register lets one more item in while the output register is stalled.
// Reset (synchronous, active low): idle, all frame state cleared, header byte 0xAA.
`timescale 1ns / 1ps

module checked_frame_receiver #(
    parameter int MAX_PAYLOAD = cfr_pkg::CFR_MAX_PAYLOAD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // byte_value, payload_index, frame_good, frame_dropped, function_code,
    // payload_length, zero pad
    output logic [47:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser,   // byte_role
    output logic        m_axis_tlast    // frame_end
);
    import cfr_pkg::*;

    logic    accept;
    t_result new_res;
    t_result r_out, r_skid;
    logic    r_out_v, r_skid_v;

    assign s_axis_tready = !r_skid_v;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cfr_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_accept   (accept),
        .i_byte     (s_axis_tdata),
        .o_result   (new_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || m_axis_tready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= accept;
            end
        end else if (accept) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || m_axis_tready) begin
            r_out <= r_skid_v ? r_skid : new_res;
        end else if (accept) begin
            r_skid <= new_res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out.byte_role;
    assign m_axis_tlast  = r_out.frame_end;
    assign m_axis_tdata  = {6'd0, r_out.payload_length, r_out.function_code,
                            r_out.frame_dropped, r_out.frame_good,
                            r_out.payload_index, r_out.byte_value};

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without output entry");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !m_axis_tready))
        else $error("skid filled while output was free");

    a_good_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[16]) |-> m_axis_tlast)
        else $error("frame_good outside frame end");

    a_end_not_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tlast && m_axis_tdata[17]))
        else $error("frame end and drop on same item");
`endif

endmodule

### hdl/cfr_parser.sv
// Frame state registers and per-item role, check and length logic.
`timescale 1ns / 1ps

module cfr_parser #(
    parameter int MAX_PAYLOAD = cfr_pkg::CFR_MAX_PAYLOAD
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    output cfr_pkg::t_result o_result
);
    import cfr_pkg::*;

    localparam int FRAME_MAX = MAX_PAYLOAD + OVERHEAD;
    localparam int CNT_W     = $clog2(FRAME_MAX + 1);

    logic [7:0]       r_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_len, n_len;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_add, n_add;
    logic [7:0]       r_func, n_func;
    logic             r_sum_ok, n_sum_ok;

    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] cnt1;
    logic [CMP_W-1:0] pidx_full;
    logic [7:0]       sum_base, add_base;
    logic             acc;
    t_role            role;
    logic [7:0]       pidx;
    logic             f_end, f_good, f_drop;

    always_comb begin
        pos       = CMP_W'(r_count);
        cnt1      = pos + CMP_W'(1);
        pidx_full = pos - CMP_W'(HEAD_BYTES);
        n_count   = r_count;
        n_len     = r_len;
        n_func    = r_func;
        n_sum_ok  = r_sum_ok;
        n_sum     = r_sum;
        n_add     = r_add;
        sum_base  = r_sum;
        add_base  = r_add;
        acc       = 1'b0;
        role      = ROLE_HUNT;
        pidx      = 8'd0;
        f_end     = 1'b0;
        f_good    = 1'b0;
        f_drop    = 1'b0;

        if (!(r_count == '0 && i_byte != r_head)) begin
            if (r_count == '0) begin
                role     = ROLE_HEAD;
                n_len    = '0;
                n_func   = 8'd0;
                sum_base = 8'd0;
                add_base = 8'd0;
                n_sum_ok = 1'b0;
                acc      = 1'b1;
            end else if (pos < CMP_W'(HEAD_BYTES)) begin
                acc = 1'b1;
                if (pos == CMP_W'(1)) begin
                    role = ROLE_SOURCE;
                end else if (pos == CMP_W'(2)) begin
                    role = ROLE_DEST;
                end else if (pos == CMP_W'(3)) begin
                    role   = ROLE_FUNCTION;
                    n_func = i_byte;
                end else if (pos == CMP_W'(4)) begin
                    role  = ROLE_LENGTH;
                    n_len = {8'd0, i_byte};
                end else begin
                    role  = ROLE_LENGTH;
                    n_len = {i_byte, r_len[7:0]};
                end
            end else if (pos < CMP_W'(r_len) + CMP_W'(HEAD_BYTES)) begin
                role = ROLE_PAYLOAD;
                acc  = 1'b1;
                // positions past 255 saturate
                pidx = (pidx_full > CMP_W'(255)) ? 8'd255 : pidx_full[7:0];
            end else if (pos == CMP_W'(r_len) + CMP_W'(HEAD_BYTES)) begin
                role     = ROLE_SUM;
                n_sum_ok = (i_byte == r_sum);
            end else begin
                role = ROLE_ADD;
            end

            if (acc) begin
                n_sum = sum_base + i_byte;
                n_add = add_base + n_sum;
            end

            n_count = CNT_W'(cnt1);
            if (cnt1 >= CMP_W'(OVERHEAD) && cnt1 == CMP_W'(n_len) + CMP_W'(OVERHEAD)) begin
                f_end   = 1'b1;
                f_good  = n_sum_ok && (i_byte == n_add);
                n_count = '0;
            end else if (cnt1 >= CMP_W'(FRAME_MAX)) begin
                f_drop  = 1'b1;
                n_count = '0;
            end
        end
    end

    always_comb begin
        o_result.byte_value     = i_byte;
        o_result.byte_role      = role;
        o_result.payload_index  = pidx;
        o_result.frame_end      = f_end;
        o_result.frame_good     = f_good;
        o_result.frame_dropped  = f_drop;
        o_result.function_code  = n_func;
        o_result.payload_length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= HEAD_RESET;
            r_count  <= '0;
            r_len    <= '0;
            r_sum    <= 8'd0;
            r_add    <= 8'd0;
            r_func   <= 8'd0;
            r_sum_ok <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_head <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_count  <= n_count;
                r_len    <= n_len;
                r_sum    <= n_sum;
                r_add    <= n_add;
                r_func   <= n_func;
                r_sum_ok <= n_sum_ok;
            end
        end
    end

endmodule
